### design/rmts_pkg.sv
// Shared types, constants and sizes for the rate monotonic task scheduler.
package rmts_pkg;

   // Size of the task table and width of the per-task time counters.
   localparam int MAX_TASKS = 8;
   localparam int TIME_BITS = 16;

   // Width of a task index inside the cell row.
   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

   // Function codes of a request transaction.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Reset value of the task count register.
   localparam logic [3:0] TASK_COUNT_RESET = 4'd8;

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_W-1:0]     idx_type;

   // Request payload.
   typedef struct packed {
      logic        func;
      logic [2:0]  task_index;
      logic [15:0] period;
      logic [15:0] budget;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic       ran_valid;
      logic [2:0] ran_task;
      logic       miss;
      logic [2:0] miss_task;
      logic       halted;
   } rsp_type;

   // Running shortest-period candidate handed from cell to cell.
   typedef struct packed {
      logic     found;
      idx_type  idx;
      time_type period;
   } sel_type;

   // First-miss marker handed from cell to cell during the period scan.
   typedef struct packed {
      logic    stop;
      idx_type idx;
   } scan_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic     load_en;
      idx_type  load_idx;
      time_type load_period;
      time_type load_budget;
      logic     commit_en;
      logic     best_found;
      idx_type  best_idx;
   } cell_ctl_type;

endpackage

### design/rmts_cell.sv
// One task cell: holds a task's timing state and forwards the selection and scan chains.
module rmts_cell (
   input  logic                  clock,
   input  rmts_pkg::idx_type     my_idx,
   input  logic                  active,
   input  rmts_pkg::cell_ctl_type ctl,
   input  rmts_pkg::sel_type     sel_in,
   output rmts_pkg::sel_type     sel_out,
   input  rmts_pkg::scan_type    scan_in,
   output rmts_pkg::scan_type    scan_out
);

   rmts_pkg::time_type period_ff;
   rmts_pkg::time_type budget_ff;
   rmts_pkg::time_type left_ff;
   rmts_pkg::time_type elapsed_ff;
   rmts_pkg::sel_type  sel_ff;
   rmts_pkg::sel_type  sel_in_val;
   rmts_pkg::scan_type scan_ff;
   rmts_pkg::scan_type scan_in_val;

   logic               take;
   logic               is_best;
   rmts_pkg::time_type left_eff;
   rmts_pkg::time_type elapsed_next;
   logic               ends;
   logic               miss_me;

   // This task replaces the candidate when it has budget and a strictly shorter period.
   always_comb begin
      take = active && (left_ff != '0) &&
             (!sel_in.found || (period_ff < sel_in.period));
      if (take) begin
         sel_in_val = '{found: 1'b1, idx: my_idx, period: period_ff};
      end else begin
         sel_in_val = sel_in;
      end
   end

   // Budget after this tick's run, next elapsed count and the miss check.
   always_comb begin
      is_best      = ctl.best_found && (ctl.best_idx == my_idx);
      left_eff     = is_best ? (left_ff - rmts_pkg::time_type'(1)) : left_ff;
      elapsed_next = (elapsed_ff == '1) ? elapsed_ff
                                        : (elapsed_ff + rmts_pkg::time_type'(1));
      ends         = (elapsed_next >= period_ff);
      miss_me      = active && ends && (left_eff != '0);
      if (scan_in.stop) begin
         scan_in_val = scan_in;
      end else if (miss_me) begin
         scan_in_val = '{stop: 1'b1, idx: my_idx};
      end else begin
         scan_in_val = '{stop: 1'b0, idx: '0};
      end
   end

   // Chain stages advance one cell per cycle.
   always_ff @(posedge clock) begin
      sel_ff  <= sel_in_val;
      scan_ff <= scan_in_val;
   end

   // Task state: written by a load, updated once at the end of a tick.
   always_ff @(posedge clock) begin
      if (ctl.load_en && (ctl.load_idx == my_idx)) begin
         period_ff  <= ctl.load_period;
         budget_ff  <= ctl.load_budget;
         left_ff    <= ctl.load_budget;
         elapsed_ff <= '0;
      end else if (ctl.commit_en) begin
         if (active && !scan_in.stop && ends && (left_eff == '0)) begin
            // The period ended with the budget used up, so a new period starts.
            elapsed_ff <= '0;
            left_ff    <= budget_ff;
         end else begin
            left_ff <= left_eff;
            if (active && !scan_in.stop) begin
               elapsed_ff <= elapsed_next;
            end
         end
      end
   end

   assign sel_out  = sel_ff;
   assign scan_out = scan_ff;

endmodule

### design/rate_monotonic_task_scheduler.sv
// Top level of the rate monotonic task scheduler: sequencer, cell row and response register.
//
// Usage: a request transaction either loads one task entry (period, budget) or
// advances time by one tick. Every request yields exactly one response
// transaction with the task that ran, the first task that missed its period
// and the halt flag. Both channels use valid and stall; a transaction moves at
// a rising edge with valid high and stall low.
// The task table lives in a row of MAX_TASKS cells. A tick runs a shortest
// period selection that travels down the row, one cell per cycle, then a
// period scan down the same row, then a commit that writes the response
// register. A load, or a tick while halted, goes straight from acceptance to
// the commit. One request is worked on at a time; req_stall is high until the
// response is written.
// A finished response waits in its register while rsp_stall is high; the next
// request is still accepted and completes its work up to the commit, which
// waits for the register to free. Reset (synchronous) clears the halt flag,
// sets the task count to eight and empties the response register; the task
// table holds no defined value until loaded. csr_wr_en writes the task count.
module rate_monotonic_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rmts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rmts_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SELECT = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   rmts_pkg::idx_type    cnt_ff, cnt_in;
   rmts_pkg::req_type    req_ff;
   logic                 halt_ff, halt_in;
   logic [3:0]           task_count_ff;
   rmts_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   rmts_pkg::sel_type    sel_chain  [rmts_pkg::MAX_TASKS+1];
   rmts_pkg::scan_type   scan_chain [rmts_pkg::MAX_TASKS+1];
   logic [rmts_pkg::MAX_TASKS-1:0] active_vec;
   rmts_pkg::cell_ctl_type ctl;

   logic                 req_fire;
   logic                 out_free;
   logic                 finish_fire;
   logic                 is_tick;
   logic                 load_ok;
   logic [31:0]          active_n;
   logic                 last_step;
   logic [rmts_pkg::IDX_W+2:0] best_wide;
   logic [rmts_pkg::IDX_W+2:0] miss_wide;

   // Handshake and decode of the held request.
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      req_fire    = req_valid && !req_stall;
      out_free    = !rsp_valid_ff || !rsp_stall;
      finish_fire = (state_ff == ST_FINISH) && out_free;
      is_tick     = (req_ff.func == rmts_pkg::FUNC_TICK);
      load_ok     = (32'(req_ff.task_index) < 32'(rmts_pkg::MAX_TASKS));
      last_step   = (cnt_ff == rmts_pkg::idx_type'(rmts_pkg::MAX_TASKS - 1));
   end

   // Entries below the saturated task count take part in scheduling.
   always_comb begin
      active_n = (32'(task_count_ff) > 32'(rmts_pkg::MAX_TASKS)) ?
                 32'(rmts_pkg::MAX_TASKS) : 32'(task_count_ff);
      for (int i = 0; i < rmts_pkg::MAX_TASKS; i++) begin
         active_vec[i] = (32'(i) < active_n);
      end
   end

   // Broadcast control for the cell row.
   always_comb begin
      ctl.load_en     = finish_fire && !is_tick && load_ok;
      ctl.load_idx    = rmts_pkg::idx_type'(req_ff.task_index);
      ctl.load_period = rmts_pkg::time_type'(req_ff.period);
      ctl.load_budget = rmts_pkg::time_type'(req_ff.budget);
      ctl.commit_en   = finish_fire && is_tick && !halt_ff;
      ctl.best_found  = sel_chain[rmts_pkg::MAX_TASKS].found;
      ctl.best_idx    = sel_chain[rmts_pkg::MAX_TASKS].idx;
   end

   // Chain heads: no candidate yet, no miss yet.
   assign sel_chain[0]  = '{found: 1'b0, idx: '0, period: '0};
   assign scan_chain[0] = '{stop: 1'b0, idx: '0};

   // Row of task cells.
   for (genvar g = 0; g < rmts_pkg::MAX_TASKS; g++) begin : g_cell
      rmts_cell u_cell (
         .clock    (clock),
         .my_idx   (rmts_pkg::idx_type'(g)),
         .active   (active_vec[g]),
         .ctl      (ctl),
         .sel_in   (sel_chain[g]),
         .sel_out  (sel_chain[g+1]),
         .scan_in  (scan_chain[g]),
         .scan_out (scan_chain[g+1])
      );
   end

   // Sequencer: selection pass, scan pass, then commit when the response slot is free.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in = '0;
               if ((req_data.func == rmts_pkg::FUNC_TICK) && !halt_ff) begin
                  state_in = ST_SELECT;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SELECT: begin
            cnt_in = cnt_ff + rmts_pkg::idx_type'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + rmts_pkg::idx_type'(1);
            if (last_step) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // Response contents and the halt flag update.
   always_comb begin
      best_wide    = {3'b000, sel_chain[rmts_pkg::MAX_TASKS].idx};
      miss_wide    = {3'b000, scan_chain[rmts_pkg::MAX_TASKS].idx};
      rsp_in       = rsp_ff;
      halt_in      = halt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (!is_tick) begin
            if (load_ok) begin
               halt_in = 1'b0;
            end
            rsp_in.halted = load_ok ? 1'b0 : halt_ff;
         end else if (halt_ff) begin
            rsp_in.halted = 1'b1;
         end else begin
            rsp_in.ran_valid = sel_chain[rmts_pkg::MAX_TASKS].found;
            rsp_in.ran_task  = sel_chain[rmts_pkg::MAX_TASKS].found ? best_wide[2:0] : 3'd0;
            rsp_in.miss      = scan_chain[rmts_pkg::MAX_TASKS].stop;
            rsp_in.miss_task = scan_chain[rmts_pkg::MAX_TASKS].stop ? miss_wide[2:0] : 3'd0;
            rsp_in.halted    = scan_chain[rmts_pkg::MAX_TASKS].stop;
            halt_in          = scan_chain[rmts_pkg::MAX_TASKS].stop;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         halt_ff       <= 1'b0;
         task_count_ff <= rmts_pkg::TASK_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            task_count_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/rmts_checker.sv
// Port-level checker for the rate monotonic task scheduler and its bind statement.
module rmts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rmts_pkg::rsp_type rsp_data
);

   // One transaction at a time: an accepted request closes the input channel.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous transaction in progress");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // A deadline miss always halts the scheduler.
   a_miss_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.miss) |-> rsp_data.halted)
      else $error("miss reported without halt");

   // The ran_task field reads zero when ran_valid is clear.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ran_valid) |-> (rsp_data.ran_task == 3'd0))
      else $error("ran_task nonzero on idle response");

   // A halted response without a new miss means no task ran.
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.halted && !rsp_data.miss) |-> !rsp_data.ran_valid)
      else $error("task ran while halted");

endmodule

bind rate_monotonic_task_scheduler rmts_checker u_rmts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
